@@ rtl/lsc_pkg.sv @@
// ============================================================================
// Line segment clipper package
// Shared widths, outcode constants, register indexes, types and helpers.
// ============================================================================
package lsc_pkg;

    localparam int COORD_BITS   = 12;
    localparam int DIFF_BITS    = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * COORD_BITS;
    localparam int QUO_BITS     = COORD_BITS;
    localparam int NUM_PASSES   = 4;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_WIN_LEFT   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_WIN_BOTTOM = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_WIN_RIGHT  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_WIN_TOP    = CFG_IDX_BITS'(3);

    localparam logic [3:0] OC_LEFT   = 4'b0001;
    localparam logic [3:0] OC_RIGHT  = 4'b0010;
    localparam logic [3:0] OC_BOTTOM = 4'b0100;
    localparam logic [3:0] OC_TOP    = 4'b1000;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    localparam t_coord RST_LEFT   = COORD_BITS'(200);
    localparam t_coord RST_BOTTOM = COORD_BITS'(100);
    localparam t_coord RST_RIGHT  = COORD_BITS'(500);
    localparam t_coord RST_TOP    = COORD_BITS'(300);

    typedef struct packed {
        t_coord left;
        t_coord bottom;
        t_coord right;
        t_coord top;
    } t_window;

    typedef struct packed {
        logic       valid;
        t_coord     x1;
        t_coord     y1;
        t_coord     x2;
        t_coord     y2;
        logic [3:0] c1;
        logic [3:0] c2;
    } t_seg;

    function automatic logic [3:0] outcode(t_coord x, t_coord y, t_window w);
        logic [3:0] c;
        c = '0;
        if (x < w.left) begin
            c = c | OC_LEFT;
        end else if (x > w.right) begin
            c = c | OC_RIGHT;
        end
        if (y < w.bottom) begin
            c = c | OC_BOTTOM;
        end else if (y > w.top) begin
            c = c | OC_TOP;
        end
        return c;
    endfunction

    function automatic logic [COORD_BITS-1:0] magnitude(logic signed [DIFF_BITS-1:0] v);
        logic signed [DIFF_BITS-1:0] n;
        n = v[DIFF_BITS-1] ? -v : v;
        return n[COORD_BITS-1:0];
    endfunction

endpackage

@@ rtl/lsc_clip_pass.sv @@
// ============================================================================
// Clip pass
// One Cohen-Sutherland pass: picks the edge, multiplies, divides one quotient
// bit per stage and moves the chosen endpoint onto the edge.
// ============================================================================
module lsc_clip_pass (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  lsc_pkg::t_window i_win,
    input  lsc_pkg::t_seg   i_seg,
    output lsc_pkg::t_seg   o_seg
);

    typedef struct packed {
        lsc_pkg::t_seg                   seg;
        logic                            active;
        logic                            use1;
        logic                            horiz;
        lsc_pkg::t_coord                 edge_pos;
        lsc_pkg::t_coord                 a0;
        logic                            neg;
        logic                            den_zero;
        logic [lsc_pkg::COORD_BITS-1:0]  den_mag;
    } t_ctx;

    // Edge selection and operand preparation.
    logic [3:0]                          sel_code;
    logic                                use1;
    logic                                horiz;
    lsc_pkg::t_coord                     edge_pos;
    lsc_pkg::t_coord                     a0;
    lsc_pkg::t_coord                     b0;
    lsc_pkg::t_coord                     a1;
    lsc_pkg::t_coord                     b1;
    logic signed [lsc_pkg::DIFF_BITS-1:0] eb;
    logic signed [lsc_pkg::DIFF_BITS-1:0] da;
    logic signed [lsc_pkg::DIFF_BITS-1:0] den;
    t_ctx                                n_ctx;

    always_comb begin
        use1     = (i_seg.c1 != 4'b0000);
        sel_code = use1 ? i_seg.c1 : i_seg.c2;
        priority if ((sel_code & lsc_pkg::OC_TOP) != 4'b0000) begin
            horiz    = 1'b1;
            edge_pos = i_win.top;
        end else if ((sel_code & lsc_pkg::OC_BOTTOM) != 4'b0000) begin
            horiz    = 1'b1;
            edge_pos = i_win.bottom;
        end else if ((sel_code & lsc_pkg::OC_RIGHT) != 4'b0000) begin
            horiz    = 1'b0;
            edge_pos = i_win.right;
        end else begin
            horiz    = 1'b0;
            edge_pos = i_win.left;
        end
        if (horiz) begin
            a0 = i_seg.x1; b0 = i_seg.y1; a1 = i_seg.x2; b1 = i_seg.y2;
        end else begin
            a0 = i_seg.y1; b0 = i_seg.x1; a1 = i_seg.y2; b1 = i_seg.x2;
        end
        eb  = lsc_pkg::DIFF_BITS'(edge_pos) - lsc_pkg::DIFF_BITS'(b0);
        da  = lsc_pkg::DIFF_BITS'(a1) - lsc_pkg::DIFF_BITS'(a0);
        den = lsc_pkg::DIFF_BITS'(b1) - lsc_pkg::DIFF_BITS'(b0);

        n_ctx.seg      = i_seg;
        n_ctx.active   = ((i_seg.c1 | i_seg.c2) != 4'b0000) &&
                         ((i_seg.c1 & i_seg.c2) == 4'b0000);
        n_ctx.use1     = use1;
        n_ctx.horiz    = horiz;
        n_ctx.edge_pos = edge_pos;
        n_ctx.a0       = a0;
        n_ctx.neg      = eb[lsc_pkg::DIFF_BITS-1] ^ da[lsc_pkg::DIFF_BITS-1] ^
                         den[lsc_pkg::DIFF_BITS-1];
        n_ctx.den_zero = (den == '0);
        n_ctx.den_mag  = lsc_pkg::magnitude(den);
    end

    t_ctx                           r_ctx;
    logic [lsc_pkg::COORD_BITS-1:0] r_eb_mag;
    logic [lsc_pkg::COORD_BITS-1:0] r_da_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.seg.valid <= 1'b0;
        end else if (i_en) begin
            r_ctx    <= n_ctx;
            r_eb_mag <= lsc_pkg::magnitude(eb);
            r_da_mag <= lsc_pkg::magnitude(da);
        end
    end

    // Index 0 holds the product; each later index has one more quotient bit.
    t_ctx                           r_dctx [0:lsc_pkg::QUO_BITS];
    logic [lsc_pkg::PROD_BITS-1:0]  r_rem  [0:lsc_pkg::QUO_BITS];
    logic [lsc_pkg::QUO_BITS-1:0]   r_quo  [0:lsc_pkg::QUO_BITS];
    logic [lsc_pkg::PROD_BITS:0]    trial  [0:lsc_pkg::QUO_BITS-1];
    logic [lsc_pkg::PROD_BITS-1:0]  prod;

    assign prod = lsc_pkg::PROD_BITS'(r_eb_mag) * lsc_pkg::PROD_BITS'(r_da_mag);

    always_comb begin
        for (int k = 0; k < lsc_pkg::QUO_BITS; k++) begin
            trial[k] = {1'b0, r_rem[k]} -
                       ((lsc_pkg::PROD_BITS + 1)'(r_dctx[k].den_mag) <<
                        (lsc_pkg::QUO_BITS - 1 - k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= lsc_pkg::QUO_BITS; k++) begin
                r_dctx[k].seg.valid <= 1'b0;
            end
        end else if (i_en) begin
            r_dctx[0] <= r_ctx;
            r_rem[0]  <= prod;
            r_quo[0]  <= '0;
            for (int k = 0; k < lsc_pkg::QUO_BITS; k++) begin
                r_dctx[k+1] <= r_dctx[k];
                if (trial[k][lsc_pkg::PROD_BITS]) begin
                    r_rem[k+1] <= r_rem[k];
                    r_quo[k+1] <= r_quo[k];
                end else begin
                    r_rem[k+1] <= trial[k][lsc_pkg::PROD_BITS-1:0];
                    r_quo[k+1] <= r_quo[k] |
                                  (lsc_pkg::QUO_BITS'(1) << (lsc_pkg::QUO_BITS - 1 - k));
                end
            end
        end
    end

    // Apply the sign, add the base coordinate and move the endpoint.
    t_ctx                                 fin;
    logic signed [lsc_pkg::DIFF_BITS-1:0] sq;
    logic signed [lsc_pkg::DIFF_BITS-1:0] sum;
    lsc_pkg::t_coord                      cross_pos;
    lsc_pkg::t_coord                      nx;
    lsc_pkg::t_coord                      ny;
    lsc_pkg::t_seg                        n_seg;
    lsc_pkg::t_seg                        r_seg;

    always_comb begin
        fin       = r_dctx[lsc_pkg::QUO_BITS];
        sq        = fin.neg ? -signed'({1'b0, r_quo[lsc_pkg::QUO_BITS]})
                            :  signed'({1'b0, r_quo[lsc_pkg::QUO_BITS]});
        sum       = lsc_pkg::DIFF_BITS'(fin.a0) + sq;
        cross_pos = fin.den_zero ? fin.a0 : sum[lsc_pkg::COORD_BITS-1:0];
        if (fin.horiz) begin
            nx = cross_pos;
            ny = fin.edge_pos;
        end else begin
            nx = fin.edge_pos;
            ny = cross_pos;
        end
        n_seg = fin.seg;
        if (fin.active) begin
            if (fin.use1) begin
                n_seg.x1 = nx;
                n_seg.y1 = ny;
                n_seg.c1 = lsc_pkg::outcode(nx, ny, i_win);
            end else begin
                n_seg.x2 = nx;
                n_seg.y2 = ny;
                n_seg.c2 = lsc_pkg::outcode(nx, ny, i_win);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg.valid <= 1'b0;
        end else if (i_en) begin
            r_seg <= n_seg;
        end
    end

    assign o_seg = r_seg;

endmodule

@@ rtl/line_segment_clipper.sv @@
// ============================================================================
// Line segment clipper
// Cohen-Sutherland clipping of one segment per transaction against a
// rectangular window held in four writable registers.
// ============================================================================
//
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_start_x/y, i_end_x/y
// result    out        o_out_valid / i_out_ready    o_visible, o_clip_*
// config    in         i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// The pipeline is one outcode stage, four clip passes of 15 stages each
// (prep, multiply, twelve divider steps, endpoint update) and one result
// register; the bit-per-stage divider in each pass sets its depth. Reset is
// synchronous and active low, clears all valid bits and loads the default
// window. When a result waits at the output the whole pipeline holds, so
// nothing is dropped or repeated; else one segment can enter every cycle.
//
module line_segment_clipper (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lsc_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [lsc_pkg::COORD_BITS-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [lsc_pkg::COORD_BITS-1:0] i_start_x,
    input  logic signed [lsc_pkg::COORD_BITS-1:0] i_start_y,
    input  logic signed [lsc_pkg::COORD_BITS-1:0] i_end_x,
    input  logic signed [lsc_pkg::COORD_BITS-1:0] i_end_y,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_visible,
    output logic signed [lsc_pkg::COORD_BITS-1:0] o_clip_start_x,
    output logic signed [lsc_pkg::COORD_BITS-1:0] o_clip_start_y,
    output logic signed [lsc_pkg::COORD_BITS-1:0] o_clip_end_x,
    output logic signed [lsc_pkg::COORD_BITS-1:0] o_clip_end_y
);

    // Window registers. The user must change them only while the pipeline is
    // empty (not enforced by the block), so every stage reads them directly.
    lsc_pkg::t_window r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= lsc_pkg::RST_LEFT;
            r_win.bottom <= lsc_pkg::RST_BOTTOM;
            r_win.right  <= lsc_pkg::RST_RIGHT;
            r_win.top    <= lsc_pkg::RST_TOP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lsc_pkg::REG_WIN_LEFT:   r_win.left   <= i_cfg_data;
                lsc_pkg::REG_WIN_BOTTOM: r_win.bottom <= i_cfg_data;
                lsc_pkg::REG_WIN_RIGHT:  r_win.right  <= i_cfg_data;
                lsc_pkg::REG_WIN_TOP:    r_win.top    <= i_cfg_data;
            endcase
        end
    end

    // The whole pipeline advances together whenever the result register is
    // free or is being drained this cycle.
    logic pipe_en;
    assign pipe_en    = !o_out_valid || i_out_ready;
    assign o_in_ready = pipe_en;

    // Entry stage: capture the endpoints and their outcodes.
    lsc_pkg::t_seg n_in;
    lsc_pkg::t_seg r_in;

    always_comb begin
        n_in.valid = i_in_valid;
        n_in.x1    = i_start_x;
        n_in.y1    = i_start_y;
        n_in.x2    = i_end_x;
        n_in.y2    = i_end_y;
        n_in.c1    = lsc_pkg::outcode(i_start_x, i_start_y, r_win);
        n_in.c2    = lsc_pkg::outcode(i_end_x, i_end_y, r_win);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (pipe_en) begin
            r_in <= n_in;
        end
    end

    // With a proper window each endpoint is clipped at most once against a
    // horizontal and once against a vertical edge before the segment is
    // either fully inside or trivially outside, so four passes settle it.
    // A settled segment passes through the remaining passes unchanged.
    lsc_pkg::t_seg pass_seg [0:lsc_pkg::NUM_PASSES];

    assign pass_seg[0] = r_in;

    for (genvar p = 0; p < lsc_pkg::NUM_PASSES; p++) begin : g_pass
        lsc_clip_pass u_pass (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_win   (r_win),
            .i_seg   (pass_seg[p]),
            .o_seg   (pass_seg[p+1])
        );
    end

    // Final decision. An inverted window has no inside point, so it always
    // rejects; testing it here keeps garbage from the earlier passes out.
    lsc_pkg::t_seg last;
    logic          accept;

    assign last   = pass_seg[lsc_pkg::NUM_PASSES];
    assign accept = ((last.c1 | last.c2) == 4'b0000) &&
                    (r_win.left <= r_win.right) && (r_win.bottom <= r_win.top);

    logic            r_valid;
    logic            r_visible;
    lsc_pkg::t_coord r_sx;
    lsc_pkg::t_coord r_sy;
    lsc_pkg::t_coord r_ex;
    lsc_pkg::t_coord r_ey;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (pipe_en) begin
            r_valid   <= last.valid;
            r_visible <= accept;
            r_sx      <= accept ? last.x1 : '0;
            r_sy      <= accept ? last.y1 : '0;
            r_ex      <= accept ? last.x2 : '0;
            r_ey      <= accept ? last.y2 : '0;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_visible      = r_visible;
    assign o_clip_start_x = r_sx;
    assign o_clip_start_y = r_sy;
    assign o_clip_end_x   = r_ex;
    assign o_clip_end_y   = r_ey;

endmodule

@@ bench/tb_top.sv @@
// ============================================================================
// Line segment clipper testbench
// Drives segments through the valid/ready input channel under several clip
// windows. Expected clip results come from an in-bench Cohen-Sutherland
// predictor and are checked in order against every result transaction.
// ============================================================================
module tb_top;

    // Clipped segment as it leaves the block.
    typedef struct packed {
        logic            visible;
        lsc_pkg::t_coord sx;
        lsc_pkg::t_coord sy;
        lsc_pkg::t_coord ex;
        lsc_pkg::t_coord ey;
    } t_clip_result;

    // The predictor runs more passes than any proper window needs, so a
    // segment that still has not settled is treated as rejected.
    localparam int PRED_PASSES = 8;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_we = 1'b0;
    logic [lsc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [lsc_pkg::COORD_BITS-1:0]   i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    lsc_pkg::t_coord                  i_start_x = '0;
    lsc_pkg::t_coord                  i_start_y = '0;
    lsc_pkg::t_coord                  i_end_x = '0;
    lsc_pkg::t_coord                  i_end_y = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic                             o_visible;
    lsc_pkg::t_coord                  o_clip_start_x;
    lsc_pkg::t_coord                  o_clip_start_y;
    lsc_pkg::t_coord                  o_clip_end_x;
    lsc_pkg::t_coord                  o_clip_end_y;

    // Bench copy of the window registers.
    longint win_left = 200;
    longint win_bottom = 100;
    longint win_right = 500;
    longint win_top = 300;

    t_clip_result pending_clips[$];
    int           mismatches = 0;
    int           cycle_count = 0;
    bit           sender_idles = 1'b0;
    bit           receiver_idles = 1'b0;
    int           stall_left = 0;

    line_segment_clipper u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Outcode of one point against the bench copy of the window.
    function automatic logic [3:0] region_code(longint x, longint y);
        logic [3:0] c;
        c = '0;
        if (x < win_left) begin
            c |= lsc_pkg::OC_LEFT;
        end else if (x > win_right) begin
            c |= lsc_pkg::OC_RIGHT;
        end
        if (y < win_bottom) begin
            c |= lsc_pkg::OC_BOTTOM;
        end else if (y > win_top) begin
            c |= lsc_pkg::OC_TOP;
        end
        return c;
    endfunction

    // Coordinate a where the line through (a0,b0)-(a1,b1) meets b = edge_pos.
    // The division truncates toward zero, as the signed divide does.
    function automatic longint line_cross(longint a0, longint b0, longint a1,
                                          longint b1, longint edge_pos);
        longint den;
        den = b1 - b0;
        if (den == 0) begin
            return a0;
        end
        return a0 + ((edge_pos - b0) * (a1 - a0)) / den;
    endfunction

    function automatic t_clip_result clip_segment(lsc_pkg::t_coord sx,
                                                  lsc_pkg::t_coord sy,
                                                  lsc_pkg::t_coord ex,
                                                  lsc_pkg::t_coord ey);
        longint       x1, y1, x2, y2, nx, ny;
        logic [3:0]   c1, c2, c;
        bit           accepted;
        t_clip_result r;
        x1 = sx; y1 = sy; x2 = ex; y2 = ey;
        c1 = region_code(x1, y1);
        c2 = region_code(x2, y2);
        accepted = 1'b0;
        for (int p = 0; p < PRED_PASSES; p++) begin
            if ((c1 | c2) == 4'b0) begin
                accepted = 1'b1;
                break;
            end
            if ((c1 & c2) != 4'b0) begin
                break;
            end
            // The first endpoint that lies outside moves; the top edge has
            // the highest priority, then bottom, right and left.
            c = (c1 != 4'b0) ? c1 : c2;
            if (c & lsc_pkg::OC_TOP) begin
                ny = win_top;
                nx = line_cross(x1, y1, x2, y2, ny);
            end else if (c & lsc_pkg::OC_BOTTOM) begin
                ny = win_bottom;
                nx = line_cross(x1, y1, x2, y2, ny);
            end else if (c & lsc_pkg::OC_RIGHT) begin
                nx = win_right;
                ny = line_cross(y1, x1, y2, x2, nx);
            end else begin
                nx = win_left;
                ny = line_cross(y1, x1, y2, x2, nx);
            end
            if (c1 != 4'b0) begin
                x1 = nx; y1 = ny;
                c1 = region_code(x1, y1);
            end else begin
                x2 = nx; y2 = ny;
                c2 = region_code(x2, y2);
            end
        end
        // A rejected segment reports all coordinates as zero.
        r = '0;
        if (accepted) begin
            r.visible = 1'b1;
            r.sx = lsc_pkg::t_coord'(x1);
            r.sy = lsc_pkg::t_coord'(y1);
            r.ex = lsc_pkg::t_coord'(x2);
            r.ey = lsc_pkg::t_coord'(y2);
        end
        return r;
    endfunction

    // Sends one segment. Valid stays high between back-to-back transactions
    // and only drops for an idle burst.
    task automatic send_segment(lsc_pkg::t_coord sx, lsc_pkg::t_coord sy,
                                lsc_pkg::t_coord ex, lsc_pkg::t_coord ey);
        t_clip_result r;
        r = clip_segment(sx, sy, ex, ey);
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x <= sx;
        i_start_y <= sy;
        i_end_x <= ex;
        i_end_y <= ey;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        pending_clips.push_back(r);
    endtask

    // Waits until every expected result has come, plus the pipeline depth so
    // the block is idle before the window changes.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_clips.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window_reg(logic [lsc_pkg::CFG_IDX_BITS-1:0] idx,
                                    longint value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= lsc_pkg::COORD_BITS'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            lsc_pkg::REG_WIN_LEFT:   win_left = value;
            lsc_pkg::REG_WIN_BOTTOM: win_bottom = value;
            lsc_pkg::REG_WIN_RIGHT:  win_right = value;
            default:                 win_top = value;
        endcase
    endtask

    task automatic set_window(longint l, longint b, longint r, longint t);
        wait_drained();
        write_window_reg(lsc_pkg::REG_WIN_LEFT, l);
        write_window_reg(lsc_pkg::REG_WIN_BOTTOM, b);
        write_window_reg(lsc_pkg::REG_WIN_RIGHT, r);
        write_window_reg(lsc_pkg::REG_WIN_TOP, t);
    endtask

    function automatic lsc_pkg::t_coord any_coord();
        return lsc_pkg::t_coord'($urandom_range(0, 4095));
    endfunction

    // A coordinate near a window span, so most segments cross edges.
    function automatic lsc_pkg::t_coord near_coord(longint lo, longint hi);
        longint v;
        v = lo - 150 + longint'($urandom_range(0, 300)) +
            longint'($urandom_range(0, 32'(hi > lo ? hi - lo : 0)));
        if (v > 2047) v = 2047;
        if (v < -2048) v = -2048;
        return lsc_pkg::t_coord'(v);
    endfunction

    // Reset window: inside, trivial rejects, each edge crossed, corners,
    // points and field extremes.
    task automatic test_default_window();
        send_segment(250, 150, 450, 250);
        send_segment(300, 200, 300, 200);
        send_segment(100, 50, 150, 400);
        send_segment(600, 150, 700, 250);
        send_segment(250, 0, 450, 50);
        send_segment(250, 400, 450, 350);
        send_segment(300, 200, 300, 500);
        send_segment(300, 200, 300, -100);
        send_segment(300, 200, 900, 200);
        send_segment(300, 200, -100, 210);
        send_segment(0, 0, 700, 400);
        send_segment(150, 350, 550, 50);
        send_segment(-2048, -2048, 2047, 2047);
        send_segment(2047, -2048, -2048, 2047);
        send_segment(-2048, 200, 2047, 201);
        send_segment(350, -2048, 351, 2047);
        send_segment(180, 350, 220, 80);
        send_segment(0, 300, 300, 0);
        send_segment(200, 100, 500, 300);
    endtask

    // Window at the extremes, then inverted, then shrunk to one point.
    task automatic test_window_extremes();
        set_window(-2048, -2048, 2047, 2047);
        send_segment(-2048, -2048, 2047, 2047);
        send_segment(2047, 0, -2048, 5);
        set_window(500, 300, 200, 100);
        send_segment(300, 200, 400, 250);
        send_segment(-2048, -2048, 2047, 2047);
        set_window(0, 0, 0, 0);
        send_segment(0, 0, 0, 0);
        send_segment(-10, -10, 10, 10);
        send_segment(-10, 10, 10, -10);
        send_segment(-5, 3, 7, -2);
        send_segment(1, 0, 5, 0);
    endtask

    task automatic random_batch(int count, bit wide_only);
        for (int i = 0; i < count; i++) begin
            if (wide_only || $urandom_range(0, 4) == 0) begin
                send_segment(any_coord(), any_coord(), any_coord(), any_coord());
            end else begin
                send_segment(near_coord(win_left, win_right),
                             near_coord(win_bottom, win_top),
                             near_coord(win_left, win_right),
                             near_coord(win_bottom, win_top));
            end
        end
    endtask

    // Random segments under a series of windows with idling on both sides,
    // one pause until fully drained, then a final stretch with no idling.
    task automatic test_random_segments();
        longint a, b;
        set_window(200, 100, 500, 300);
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        random_batch(150, 1'b0);
        wait_drained();
        random_batch(100, 1'b1);
        for (int w = 0; w < 4; w++) begin
            a = longint'($urandom_range(0, 3000)) - 2048;
            b = a + longint'($urandom_range(0, 1000));
            if (b > 2047) b = 2047;
            set_window(a, -a / 2, b, -a / 2 + (b - a) / 2);
            random_batch(80, 1'b0);
        end
        set_window(-2048, 2047 - 40, -2048 + 40, 2047);
        random_batch(60, 1'b0);
        set_window(-300, -200, 300, 200);
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        random_batch(120, 1'b0);
    endtask

    // Receiver with random stall bursts.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Each result transaction is compared with the oldest expected clip.
    always @(posedge i_clk) begin
        t_clip_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_clips.size() == 0) begin
                $display("%0t: unexpected result transaction", $time);
                mismatches++;
            end else begin
                want = pending_clips.pop_front();
                if (o_visible !== want.visible) begin
                    $display("%0t: visible expected %0d actual %0d",
                             $time, want.visible, o_visible);
                    mismatches++;
                end
                if (o_clip_start_x !== want.sx) begin
                    $display("%0t: clip_start_x expected %0d actual %0d",
                             $time, want.sx, o_clip_start_x);
                    mismatches++;
                end
                if (o_clip_start_y !== want.sy) begin
                    $display("%0t: clip_start_y expected %0d actual %0d",
                             $time, want.sy, o_clip_start_y);
                    mismatches++;
                end
                if (o_clip_end_x !== want.ex) begin
                    $display("%0t: clip_end_x expected %0d actual %0d",
                             $time, want.ex, o_clip_end_x);
                    mismatches++;
                end
                if (o_clip_end_y !== want.ey) begin
                    $display("%0t: clip_end_y expected %0d actual %0d",
                             $time, want.ey, o_clip_end_y);
                    mismatches++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_window();
        test_window_extremes();
        test_random_segments();
        wait_drained();
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lsc_pkg.sv
rtl/lsc_clip_pass.sv
rtl/line_segment_clipper.sv
bench/tb_top.sv
